[design/btlpm_pkg.sv]
`timescale 1ns / 1ps

package btlpm_pkg;

    // Table sizing
    localparam int NODE_COUNT    = 1024;
    localparam int NODE_BITS     = $clog2(NODE_COUNT);
    localparam int CNT_BITS      = $clog2(NODE_COUNT + 1);
    localparam int ROUTE_ID_BITS = 16;
    localparam int ADDRESS_BITS  = 32;
    localparam int BIT_IDX_BITS  = (ADDRESS_BITS > 1) ? $clog2(ADDRESS_BITS) : 1;
    localparam int DEPTH_BITS    = $clog2(ADDRESS_BITS + 1);

    // Fixed field widths of the ports
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 6;
    localparam int RID_W    = 16;
    localparam int STATUS_W = 2;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISS = 2'd2;

    // One trie node as stored in the node memory
    typedef struct packed {
        logic [NODE_BITS-1:0]     link1;
        logic [NODE_BITS-1:0]     link0;
        logic                     valid;
        logic [ROUTE_ID_BITS-1:0] route;
    } node_t;

    // Node memory request, one port shared by read and write
    typedef struct packed {
        logic                 rd_en;
        logic                 wr_en;
        logic [NODE_BITS-1:0] addr;
        node_t                wdata;
    } ram_req_t;

    // Result beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                hit;
        logic [RID_W-1:0]    route;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CHECK,
        S_MAKE,
        S_FIN,
        S_DONE
    } state_t;

endpackage

[design/binary_trie_longest_prefix_match_unit.sv]
`timescale 1ns / 1ps
// Flow: a lookup reads the root, then one node per walked trie level, and ends in S_DONE;
//   an insert walks, checks the free pool, writes one node per created level, then the route.
// Throughput: one command at a time; the trie walk costs one node memory read per level.
// A new command is taken while the previous result still waits in the output register.
// Reset: node count returns to one (root only), the root reads as empty until written;
//   the node memory itself is not swept.

module binary_trie_longest_prefix_match_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [btlpm_pkg::ADDR_W-1:0]        address,
    input  logic [btlpm_pkg::LEN_W-1:0]         prefix_length,
    input  logic [btlpm_pkg::RID_W-1:0]         route_id,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [btlpm_pkg::STATUS_W-1:0]      status,
    output logic                                hit,
    output logic [btlpm_pkg::RID_W-1:0]         matched_route
);

    logic                 idle;
    logic                 in_fire;
    logic                 res_valid;
    logic                 res_ready;
    btlpm_pkg::result_t   res;
    btlpm_pkg::ram_req_t  ram_req;
    btlpm_pkg::node_t     ram_rdata;

    logic                 out_valid_reg, out_valid_next;
    btlpm_pkg::result_t   out_reg, out_next;

    assign in_ready  = idle;
    assign in_fire   = in_valid && idle;
    assign res_ready = !out_valid_reg || out_ready;

    btlpm_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .command       (command),
        .address       (address),
        .prefix_length (prefix_length),
        .route_id      (route_id),
        .idle          (idle),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .ram_req       (ram_req),
        .ram_rdata     (ram_rdata)
    );

    btlpm_node_ram u_node_ram
    (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // Output register: load a finished result when the slot is free or is emptied in this cycle
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign hit           = out_reg.hit;
    assign matched_route = out_reg.route;

endmodule

[design/btlpm_node_ram.sv]
`timescale 1ns / 1ps

module btlpm_node_ram
(
    input  logic                clk,
    input  btlpm_pkg::ram_req_t req,
    output btlpm_pkg::node_t    rdata
);

    btlpm_pkg::node_t mem [btlpm_pkg::NODE_COUNT];
    btlpm_pkg::node_t rdata_reg;

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/btlpm_ctrl.sv]
`timescale 1ns / 1ps

module btlpm_ctrl
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_fire,
    input  logic                                command,
    input  logic [btlpm_pkg::ADDR_W-1:0]        address,
    input  logic [btlpm_pkg::LEN_W-1:0]         prefix_length,
    input  logic [btlpm_pkg::RID_W-1:0]         route_id,
    output logic                                idle,
    output logic                                res_valid,
    input  logic                                res_ready,
    output btlpm_pkg::result_t                  res,
    output btlpm_pkg::ram_req_t                 ram_req,
    input  btlpm_pkg::node_t                    ram_rdata
);

    btlpm_pkg::state_t state_reg, state_next;

    logic                                   cmd_reg, cmd_next;
    logic [btlpm_pkg::ADDRESS_BITS-1:0]     addr_reg, addr_next;
    logic [btlpm_pkg::DEPTH_BITS-1:0]       len_reg, len_next;
    logic [btlpm_pkg::ROUTE_ID_BITS-1:0]    rid_reg, rid_next;
    logic [btlpm_pkg::NODE_BITS-1:0]        node_reg, node_next;
    logic [btlpm_pkg::DEPTH_BITS-1:0]       depth_reg, depth_next;
    btlpm_pkg::node_t                       cur_reg, cur_next;
    logic [btlpm_pkg::CNT_BITS-1:0]         used_reg, used_next;
    logic                                   found_reg, found_next;
    logic [btlpm_pkg::ROUTE_ID_BITS-1:0]    best_reg, best_next;
    logic [btlpm_pkg::STATUS_W-1:0]         status_reg, status_next;
    logic                                   root_init_reg, root_init_next;
    logic                                   root_rd_reg, root_rd_next;

    btlpm_pkg::node_t                       node_rd;
    logic [btlpm_pkg::BIT_IDX_BITS-1:0]     bit_pos;
    logic                                   bit_sel;
    logic [btlpm_pkg::NODE_BITS-1:0]        nx;
    logic                                   more_bits;
    logic                                   at_bottom;
    logic                                   advance;
    logic [btlpm_pkg::DEPTH_BITS-1:0]       need;
    logic                                   pool_short;
    logic [btlpm_pkg::DEPTH_BITS-1:0]       in_len_sat;
    logic [btlpm_pkg::NODE_BITS-1:0]        new_node;
    btlpm_pkg::node_t                       linked;
    btlpm_pkg::node_t                       routed;

    // Root reads as empty until it has been written once
    assign node_rd = root_rd_reg ? '0 : ram_rdata;

    // Address bit for the current depth, MSB first
    assign bit_pos = btlpm_pkg::BIT_IDX_BITS'(btlpm_pkg::ADDRESS_BITS - 1)
                   - depth_reg[btlpm_pkg::BIT_IDX_BITS-1:0];
    assign bit_sel = addr_reg[bit_pos];
    assign nx      = bit_sel ? node_rd.link1 : node_rd.link0;

    assign more_bits = (depth_reg < len_reg);
    assign at_bottom = (depth_reg == btlpm_pkg::DEPTH_BITS'(btlpm_pkg::ADDRESS_BITS));
    assign advance   = (nx != '0) &&
                       ((cmd_reg == btlpm_pkg::CMD_LOOKUP) ? !at_bottom : more_bits);

    // Free-pool check: nodes_used + need must stay within the pool
    assign need       = len_reg - depth_reg;
    assign pool_short = ({1'b0, used_reg} + (btlpm_pkg::CNT_BITS + 1)'(need))
                      > (btlpm_pkg::CNT_BITS + 1)'(btlpm_pkg::NODE_COUNT);

    assign in_len_sat = (prefix_length > btlpm_pkg::LEN_W'(btlpm_pkg::ADDRESS_BITS))
                      ? btlpm_pkg::DEPTH_BITS'(btlpm_pkg::ADDRESS_BITS)
                      : btlpm_pkg::DEPTH_BITS'(prefix_length);

    assign new_node = used_reg[btlpm_pkg::NODE_BITS-1:0];

    // Parent entry with the new child hooked in
    always_comb
    begin
        linked = cur_reg;
        if (bit_sel)
        begin
            linked.link1 = new_node;
        end
        else
        begin
            linked.link0 = new_node;
        end
    end

    // Final node with the route stored
    always_comb
    begin
        routed       = cur_reg;
        routed.valid = 1'b1;
        routed.route = rid_reg;
    end

    // Next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        len_next       = len_reg;
        rid_next       = rid_reg;
        node_next      = node_reg;
        depth_next     = depth_reg;
        cur_next       = cur_reg;
        used_next      = used_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        status_next    = status_reg;
        root_rd_next   = root_rd_reg;

        case (state_reg)
            btlpm_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next     = command;
                    addr_next    = address[btlpm_pkg::ADDRESS_BITS-1:0];
                    len_next     = in_len_sat;
                    rid_next     = route_id[btlpm_pkg::ROUTE_ID_BITS-1:0];
                    node_next    = '0;
                    depth_next   = '0;
                    found_next   = 1'b0;
                    best_next    = '0;
                    root_rd_next = !root_init_reg;
                    state_next   = btlpm_pkg::S_EVAL;
                end
            end
            btlpm_pkg::S_EVAL:
            begin
                if ((cmd_reg == btlpm_pkg::CMD_LOOKUP) && node_rd.valid)
                begin
                    found_next = 1'b1;
                    best_next  = node_rd.route;
                end
                if (advance)
                begin
                    node_next    = nx;
                    depth_next   = depth_reg + 1'b1;
                    root_rd_next = 1'b0;
                end
                else if (cmd_reg == btlpm_pkg::CMD_LOOKUP)
                begin
                    status_next = (found_reg || node_rd.valid) ? btlpm_pkg::STAT_DONE
                                                               : btlpm_pkg::STAT_MISS;
                    state_next  = btlpm_pkg::S_DONE;
                end
                else
                begin
                    cur_next   = node_rd;
                    state_next = btlpm_pkg::S_CHECK;
                end
            end
            btlpm_pkg::S_CHECK:
            begin
                if (pool_short)
                begin
                    status_next = btlpm_pkg::STAT_FULL;
                    state_next  = btlpm_pkg::S_DONE;
                end
                else if (more_bits)
                begin
                    state_next = btlpm_pkg::S_MAKE;
                end
                else
                begin
                    state_next = btlpm_pkg::S_FIN;
                end
            end
            btlpm_pkg::S_MAKE:
            begin
                node_next  = new_node;
                used_next  = used_reg + 1'b1;
                depth_next = depth_reg + 1'b1;
                cur_next   = '0;
                if ((depth_reg + 1'b1) == len_reg)
                begin
                    state_next = btlpm_pkg::S_FIN;
                end
            end
            btlpm_pkg::S_FIN:
            begin
                status_next = btlpm_pkg::STAT_DONE;
                state_next  = btlpm_pkg::S_DONE;
            end
            btlpm_pkg::S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = btlpm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = btlpm_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs: memory request, handshake, result
    always_comb
    begin
        ram_req       = '0;
        idle          = 1'b0;
        res_valid     = 1'b0;
        res.status    = status_reg;
        res.hit       = found_reg;
        res.route     = btlpm_pkg::RID_W'(best_reg);

        case (state_reg)
            btlpm_pkg::S_IDLE:
            begin
                idle          = 1'b1;
                ram_req.rd_en = in_fire;
                ram_req.addr  = '0;
            end
            btlpm_pkg::S_EVAL:
            begin
                ram_req.rd_en = advance;
                ram_req.addr  = nx;
            end
            btlpm_pkg::S_MAKE:
            begin
                ram_req.wr_en = 1'b1;
                ram_req.addr  = node_reg;
                ram_req.wdata = linked;
            end
            btlpm_pkg::S_FIN:
            begin
                ram_req.wr_en = !cur_reg.valid;
                ram_req.addr  = node_reg;
                ram_req.wdata = routed;
            end
            btlpm_pkg::S_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                idle = 1'b0;
            end
        endcase
    end

    // Root becomes real memory content once written
    assign root_init_next = root_init_reg || (ram_req.wr_en && (ram_req.addr == '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= btlpm_pkg::S_IDLE;
            used_reg      <= btlpm_pkg::CNT_BITS'(1);
            root_init_reg <= 1'b0;
            root_rd_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            root_init_reg <= root_init_next;
            root_rd_reg   <= root_rd_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        addr_reg   <= addr_next;
        len_reg    <= len_next;
        rid_reg    <= rid_next;
        node_reg   <= node_next;
        depth_reg  <= depth_next;
        cur_reg    <= cur_next;
        found_reg  <= found_next;
        best_reg   <= best_next;
        status_reg <= status_next;
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int TAIL_CYCLES = 100;
    localparam int POOL_SLOTS  = 64;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic                           command;
    logic [btlpm_pkg::ADDR_W-1:0]   address;
    logic [btlpm_pkg::LEN_W-1:0]    prefix_length;
    logic [btlpm_pkg::RID_W-1:0]    route_id;
    logic                           out_valid;
    logic                           out_ready;
    logic [btlpm_pkg::STATUS_W-1:0] status;
    logic                           hit;
    logic [btlpm_pkg::RID_W-1:0]    matched_route;

    binary_trie_longest_prefix_match_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .address       (address),
        .prefix_length (prefix_length),
        .route_id      (route_id),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .hit           (hit),
        .matched_route (matched_route)
    );

    // Mirror of the trie: child links, route flags and ids, allocation count
    bit [btlpm_pkg::NODE_BITS-1:0]     child_of [btlpm_pkg::NODE_COUNT][2];
    bit                                route_valid [btlpm_pkg::NODE_COUNT];
    bit [btlpm_pkg::ROUTE_ID_BITS-1:0] route_of [btlpm_pkg::NODE_COUNT];
    int unsigned                       nodes_in_use = 1;

    // Results still owed by the block, oldest first
    btlpm_pkg::result_t replies_due[$];
    btlpm_pkg::result_t head_reply;

    // Recently inserted prefixes, reused to build matching traffic
    logic [btlpm_pkg::ADDR_W-1:0] known_addr[$];
    int unsigned                  known_len[$];

    int unsigned errors    = 0;
    int unsigned n_inserts = 0;
    int unsigned n_full    = 0;
    int unsigned n_lookups = 0;
    int unsigned n_hits    = 0;

    bit          tx_gaps_on   = 1'b1;
    bit          rx_stalls_on = 1'b1;
    int unsigned rx_hold_left = 0;
    int unsigned rx_stall_left = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(64'd40_000_000);
        $display("tb_top NOT OK");
        $finish;
    end

    // Deepest node already on the path of the first len bits of addr
    function automatic int unsigned prefix_depth(input logic [btlpm_pkg::ADDR_W-1:0] addr,
                                                 input int unsigned len,
                                                 output int unsigned node);
        int unsigned depth;
        bit [btlpm_pkg::NODE_BITS-1:0] nx;
        node  = 0;
        depth = 0;
        while (depth < len)
        begin
            nx = child_of[node][addr[btlpm_pkg::ADDRESS_BITS-1-depth]];
            if (nx == 0)
                break;
            node = nx;
            depth++;
        end
        return depth;
    endfunction

    // Apply one command to the mirror and return the result it must produce
    function automatic btlpm_pkg::result_t trie_predict(
        input logic cmd, input logic [btlpm_pkg::ADDR_W-1:0] addr,
        input logic [btlpm_pkg::LEN_W-1:0] len_in,
        input logic [btlpm_pkg::RID_W-1:0] rid);
        btlpm_pkg::result_t r;
        int unsigned len, depth, node;
        bit [btlpm_pkg::NODE_BITS-1:0] nx;
        bit found;
        bit [btlpm_pkg::ROUTE_ID_BITS-1:0] best;
        r     = '0;
        found = 1'b0;
        best  = '0;
        if (cmd == btlpm_pkg::CMD_INSERT)
        begin
            n_inserts++;
            len   = (len_in > btlpm_pkg::ADDRESS_BITS) ? btlpm_pkg::ADDRESS_BITS : len_in;
            depth = prefix_depth(addr, len, node);
            if (len - depth > btlpm_pkg::NODE_COUNT - nodes_in_use)
            begin
                // not enough free nodes: table untouched
                r.status = btlpm_pkg::STAT_FULL;
                n_full++;
            end
            else
            begin
                while (depth < len)
                begin
                    child_of[nodes_in_use][0]   = '0;
                    child_of[nodes_in_use][1]   = '0;
                    route_valid[nodes_in_use]   = 1'b0;
                    route_of[nodes_in_use]      = '0;
                    child_of[node][addr[btlpm_pkg::ADDRESS_BITS-1-depth]] =
                        btlpm_pkg::NODE_BITS'(nodes_in_use);
                    node = nodes_in_use;
                    nodes_in_use++;
                    depth++;
                end
                // an existing route keeps its id
                if (!route_valid[node])
                begin
                    route_valid[node] = 1'b1;
                    route_of[node]    = rid[btlpm_pkg::ROUTE_ID_BITS-1:0];
                end
                r.status = btlpm_pkg::STAT_DONE;
            end
        end
        else
        begin
            n_lookups++;
            node  = 0;
            depth = 0;
            forever
            begin
                if (route_valid[node])
                begin
                    found = 1'b1;
                    best  = route_of[node];
                end
                if (depth >= btlpm_pkg::ADDRESS_BITS)
                    break;
                nx = child_of[node][addr[btlpm_pkg::ADDRESS_BITS-1-depth]];
                if (nx == 0)
                    break;
                node = nx;
                depth++;
            end
            if (found)
            begin
                r.status = btlpm_pkg::STAT_DONE;
                r.hit    = 1'b1;
                r.route  = btlpm_pkg::RID_W'(best);
                n_hits++;
            end
            else
                r.status = btlpm_pkg::STAT_MISS;
        end
        return r;
    endfunction

    function automatic logic [btlpm_pkg::ADDR_W-1:0] prefix_mask(input int unsigned len);
        if (len == 0)
            return '0;
        if (len >= btlpm_pkg::ADDR_W)
            return '1;
        return ~(btlpm_pkg::ADDR_W'(0)) << (btlpm_pkg::ADDR_W - len);
    endfunction

    function automatic void remember_prefix(input logic [btlpm_pkg::ADDR_W-1:0] addr,
                                            input int unsigned len);
        int unsigned k;
        if (len > btlpm_pkg::ADDRESS_BITS)
            len = btlpm_pkg::ADDRESS_BITS;
        if (known_addr.size() < POOL_SLOTS)
        begin
            known_addr.push_back(addr);
            known_len.push_back(len);
        end
        else
        begin
            k = $urandom_range(0, POOL_SLOTS - 1);
            known_addr[k] = addr;
            known_len[k]  = len;
        end
    endfunction

    // Offer one command beat, optionally after an idle burst; ends on a falling edge
    task automatic send_command(input logic cmd, input logic [btlpm_pkg::ADDR_W-1:0] addr,
                                input logic [btlpm_pkg::LEN_W-1:0] len,
                                input logic [btlpm_pkg::RID_W-1:0] rid);
        int unsigned gap;
        gap = 0;
        if (tx_gaps_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 19);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        address       <= addr;
        prefix_length <= len;
        route_id      <= rid;
        do
            @(posedge clk);
        while (!in_ready);
        replies_due.push_back(trie_predict(cmd, addr, len, rid));
        @(negedge clk);
    endtask

    // Drop valid before any wait that is not a handshake
    task automatic tx_idle();
        in_valid <= 1'b0;
    endtask

    // One random command, mostly built around prefixes already in the table
    task automatic random_command(input int unsigned max_fresh_len);
        int unsigned pick, k, len;
        logic [btlpm_pkg::ADDR_W-1:0] addr;
        pick = $urandom_range(0, 99);
        k    = (known_addr.size() != 0) ? $urandom_range(0, known_addr.size() - 1) : 0;
        if (pick < 45)
        begin
            if (known_addr.size() != 0 && pick < 36)
                addr = (known_addr[k] & prefix_mask(known_len[k]))
                     | ($urandom() & ~prefix_mask(known_len[k]));
            else
                addr = $urandom();
            send_command(btlpm_pkg::CMD_LOOKUP, addr, btlpm_pkg::LEN_W'($urandom()),
                         btlpm_pkg::RID_W'($urandom()));
        end
        else
        begin
            addr = $urandom();
            if (known_addr.size() != 0 && pick < 62)
            begin
                // same prefix again, junk in the ignored bits
                len  = known_len[k];
                addr = (known_addr[k] & prefix_mask(len)) | (addr & ~prefix_mask(len));
            end
            else if (known_addr.size() != 0 && pick < 85)
            begin
                // longer prefix under an existing one
                len  = known_len[k] + $urandom_range(1, 4);
                if (len > btlpm_pkg::ADDRESS_BITS)
                    len = btlpm_pkg::ADDRESS_BITS;
                addr = (known_addr[k] & prefix_mask(known_len[k]))
                     | (addr & ~prefix_mask(known_len[k]));
            end
            else if (pick < 95 || max_fresh_len < btlpm_pkg::ADDRESS_BITS)
                len = $urandom_range(0, max_fresh_len);
            else
                len = $urandom_range(btlpm_pkg::ADDRESS_BITS + 1, 63);
            remember_prefix(addr, len);
            send_command(btlpm_pkg::CMD_INSERT, addr, btlpm_pkg::LEN_W'(len),
                         btlpm_pkg::RID_W'($urandom()));
        end
    endtask

    // Empty table, nesting, duplicates, default route, host routes, saturation
    task automatic test_directed();
        send_command(btlpm_pkg::CMD_LOOKUP, 32'h0000_0000, 6'd0,  16'h0000);
        send_command(btlpm_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
        send_command(btlpm_pkg::CMD_INSERT, 32'hC0A8_0000, 6'd16, 16'h1234);
        send_command(btlpm_pkg::CMD_LOOKUP, 32'hC0A8_0105, 6'd0,  16'h0000);
        send_command(btlpm_pkg::CMD_INSERT, 32'hC0A8_0100, 6'd24, 16'hFFFF);
        send_command(btlpm_pkg::CMD_LOOKUP, 32'hC0A8_01FF, 6'd0,  16'h0000);
        send_command(btlpm_pkg::CMD_LOOKUP, 32'hC0A8_0201, 6'd0,  16'h0000);
        send_command(btlpm_pkg::CMD_INSERT, 32'hC0A8_0000, 6'd16, 16'h5555);
        send_command(btlpm_pkg::CMD_LOOKUP, 32'hC0A8_FFFF, 6'd0,  16'h0000);
        send_command(btlpm_pkg::CMD_LOOKUP, 32'h0A00_0001, 6'd0,  16'h0000);
        send_command(btlpm_pkg::CMD_INSERT, 32'hDEAD_BEEF, 6'd0,  16'h0000);
        send_command(btlpm_pkg::CMD_LOOKUP, 32'h0A00_0001, 6'd0,  16'h0000);
        send_command(btlpm_pkg::CMD_INSERT, 32'h1234_5678, 6'd0,  16'hBEEF);
        send_command(btlpm_pkg::CMD_INSERT, 32'hFFFF_FFFF, 6'd32, 16'hA5A5);
        send_command(btlpm_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0,  16'h0000);
        send_command(btlpm_pkg::CMD_LOOKUP, 32'hFFFF_FFFE, 6'd0,  16'h0000);
        send_command(btlpm_pkg::CMD_INSERT, 32'h0000_0000, 6'd63, 16'h8001);
        send_command(btlpm_pkg::CMD_LOOKUP, 32'h0000_0000, 6'd0,  16'h0000);
        send_command(btlpm_pkg::CMD_INSERT, 32'h8000_0000, 6'd33, 16'h7FFF);
        send_command(btlpm_pkg::CMD_LOOKUP, 32'h8000_0000, 6'd0,  16'h0000);
        send_command(btlpm_pkg::CMD_LOOKUP, 32'h8000_0001, 6'd0,  16'h0000);
        send_command(btlpm_pkg::CMD_INSERT, 32'h0AFF_FFFF, 6'd8,  16'h0101);
        send_command(btlpm_pkg::CMD_LOOKUP, 32'h0A12_3456, 6'd0,  16'h0000);
        remember_prefix(32'hC0A8_0000, 16);
        remember_prefix(32'hC0A8_0100, 24);
        remember_prefix(32'h0A00_0000, 8);
    endtask

    task automatic test_random_mixed(input int unsigned count, input int unsigned max_fresh_len);
        repeat (count) random_command(max_fresh_len);
    endtask

    // Output held off long enough that the block backs up into its input
    task automatic test_receiver_hold();
        tx_gaps_on = 1'b0;
        tx_idle();
        @(posedge clk);
        rx_hold_left = 400;
        @(negedge clk);
        repeat (12) random_command(10);
        tx_gaps_on = 1'b1;
    endtask

    // Sender goes quiet until every owed result is back
    task automatic test_sender_drain();
        tx_idle();
        wait (replies_due.size() == 0);
        @(negedge clk);
        repeat (4) random_command(10);
    endtask

    // Fill the node pool to the last node, then try to grow past it
    task automatic test_pool_exhaustion();
        int unsigned free_nodes, depth, best_depth, node, room;
        logic [btlpm_pkg::ADDR_W-1:0] addr, best_addr;
        while (btlpm_pkg::NODE_COUNT - nodes_in_use > 40)
            send_command(btlpm_pkg::CMD_INSERT, $urandom(), 6'd32,
                         btlpm_pkg::RID_W'($urandom()));
        best_addr = '0;
        repeat (8)
        begin
            free_nodes = btlpm_pkg::NODE_COUNT - nodes_in_use;
            if (free_nodes != 0)
            begin
                best_depth = btlpm_pkg::ADDRESS_BITS + 1;
                repeat (64)
                begin
                    addr  = $urandom();
                    depth = prefix_depth(addr, btlpm_pkg::ADDRESS_BITS, node);
                    if (depth < best_depth)
                    begin
                        best_depth = depth;
                        best_addr  = addr;
                    end
                end
                room = btlpm_pkg::ADDRESS_BITS - best_depth;
                // one node more than is left: must be refused
                if (free_nodes < room)
                    send_command(btlpm_pkg::CMD_INSERT, best_addr,
                                 btlpm_pkg::LEN_W'(best_depth + free_nodes + 1),
                                 btlpm_pkg::RID_W'($urandom()));
                send_command(btlpm_pkg::CMD_INSERT, best_addr,
                             btlpm_pkg::LEN_W'(best_depth +
                                               ((free_nodes < room) ? free_nodes : room)),
                             btlpm_pkg::RID_W'($urandom()));
            end
        end
        send_command(btlpm_pkg::CMD_INSERT, $urandom(), 6'd32, btlpm_pkg::RID_W'($urandom()));
        send_command(btlpm_pkg::CMD_LOOKUP, best_addr, 6'd0, 16'h0000);
        send_command(btlpm_pkg::CMD_INSERT, $urandom(), 6'd0, btlpm_pkg::RID_W'($urandom()));
    endtask

    // Receiver: long hold on request, otherwise random stall bursts
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left != 0)
            begin
                rx_hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_stall_left != 0)
            begin
                rx_stall_left--;
                out_ready <= 1'b0;
            end
            else if (rx_stalls_on && $urandom_range(0, 7) == 0)
            begin
                rx_stall_left = $urandom_range(1, 19) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: result beat with nothing owed: status %0d hit %0d route %h",
                         $time, status, hit, matched_route);
                errors++;
            end
            else
            begin
                head_reply = replies_due.pop_front();
                if (status !== head_reply.status)
                begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, head_reply.status, status);
                    errors++;
                end
                if (hit !== head_reply.hit)
                begin
                    $display("%0t: hit expected %0d, got %0d", $time, head_reply.hit, hit);
                    errors++;
                end
                if (matched_route !== head_reply.route)
                begin
                    $display("%0t: matched_route expected %h, got %h",
                             $time, head_reply.route, matched_route);
                    errors++;
                end
            end
        end
    end

    // Test sequence
    initial
    begin
        in_valid      = 1'b0;
        command       = btlpm_pkg::CMD_INSERT;
        address       = '0;
        prefix_length = '0;
        route_id      = '0;
        rst_n         = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mixed(550, 10);
        test_receiver_hold();
        test_sender_drain();
        test_pool_exhaustion();
        test_random_mixed(1000, btlpm_pkg::ADDRESS_BITS);

        // closing stretch at full rate on both sides
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        test_random_mixed(300, btlpm_pkg::ADDRESS_BITS);

        tx_idle();
        wait (replies_due.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (replies_due.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, replies_due.size());
            errors++;
        end

        $display("Sent %0d inserts (%0d refused, table full) and %0d lookups (%0d hits).",
                 n_inserts, n_full, n_lookups, n_hits);
        $display("Trie used %0d of %0d nodes; long output hold and input drain pause included.",
                 nodes_in_use, btlpm_pkg::NODE_COUNT);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
